/* sv/gspf_pkg.sv */
// Shared types and constants for the GPI status frame parser.
package gspf_pkg;

	localparam int PIN_COUNT = 16;

	localparam int FIRST_DIGIT_POS = 6;
	localparam int LAST_DIGIT_POS = 4 + 2 * PIN_COUNT;
	localparam int POS_W = $clog2(LAST_DIGIT_POS + 2);

	localparam int MODE_W = 2;
	localparam int BYTE_W = 8;
	localparam int PIN_W = 4;
	localparam int UNIT_W = 4;

	localparam logic [MODE_W-1:0] MODE_STATUS = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FORCE_ON = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FORCE_OFF = 2'd2;
	localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd3;

	localparam logic [BYTE_W-1:0] CH_S = 8'h53;
	localparam logic [BYTE_W-1:0] CH_P = 8'h50;
	localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_A = 8'h41;
	localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
	localparam logic [BYTE_W-1:0] CH_ONE = 8'h31;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [PIN_COUNT-1:0] pins_t;

	typedef struct packed {
		pos_t pos;
		pins_t levels;
		pins_t masks;
	} parse_state_t;

	typedef struct packed {
		logic valid;
		logic [PIN_W-1:0] pin;
		logic level;
	} change_t;

endpackage

/* sv/gspf_step.sv */
// Next-state and change-word logic for one accepted word of the parser.
module gspf_step
	import gspf_pkg::*;
(
	input parse_state_t cur,
	input logic [UNIT_W-1:0] unit_number,
	input logic [MODE_W-1:0] mode,
	input logic [BYTE_W-1:0] status_byte,
	input logic [PIN_W-1:0] pin_select,
	output parse_state_t nxt,
	output change_t change
);

	localparam logic [PIN_W:0] PIN_LIMIT = (PIN_W + 1)'(PIN_COUNT);
	localparam pos_t LAST_POS = POS_W'(LAST_DIGIT_POS);
	localparam pos_t FIRST_POS = POS_W'(FIRST_DIGIT_POS);

	pos_t pos_off;
	logic [PIN_W-1:0] digit_pin;
	pins_t digit_sel;
	pins_t cmd_sel;
	logic is_digit;
	logic digit_lvl;
	logic cmd_in_range;

	always_comb begin
		pos_off = cur.pos - FIRST_POS;
		digit_pin = PIN_W'(pos_off >> 1);
		digit_sel = PIN_COUNT'(1) << digit_pin;
		cmd_sel = PIN_COUNT'(1) << pin_select;
		is_digit = (status_byte == CH_ZERO) || (status_byte == CH_ONE);
		digit_lvl = (status_byte == CH_ONE);
		cmd_in_range = ({1'b0, pin_select} < PIN_LIMIT);

		nxt = cur;
		change.valid = 1'b0;
		change.pin = pin_select;
		change.level = 1'b0;

		case (mode)
			MODE_STATUS: begin
				change.pin = digit_pin;
				change.level = digit_lvl;
				if (cur.pos == '0) begin
					if (status_byte == CH_S) begin
						nxt.pos = POS_W'(1);
					end
				end else if (cur.pos == POS_W'(1)) begin
					nxt.pos = (status_byte == (CH_ZERO + BYTE_W'(unit_number))) ?
						POS_W'(2) : '0;
				end else if (cur.pos == POS_W'(2)) begin
					nxt.pos = (status_byte == CH_P) ? POS_W'(3) : '0;
				end else if (cur.pos == POS_W'(3)) begin
					nxt.pos = (status_byte == CH_COMMA) ? POS_W'(4) : '0;
				end else if (cur.pos == POS_W'(4)) begin
					nxt.pos = (status_byte == CH_A) ? POS_W'(5) : '0;
				end else if (cur.pos > LAST_POS) begin
					nxt.pos = '0;
				end else if (cur.pos[0]) begin
					nxt.pos = (status_byte == CH_COMMA) ? cur.pos + POS_W'(1) : '0;
				end else if (is_digit) begin
					nxt.pos = cur.pos + POS_W'(1);
					if (((cur.masks & digit_sel) == '0) &&
						(((cur.levels & digit_sel) != '0) != digit_lvl)) begin
						nxt.levels = digit_lvl ? (cur.levels | digit_sel) :
							(cur.levels & ~digit_sel);
						change.valid = 1'b1;
					end
				end
			end
			MODE_FORCE_ON: begin
				change.level = 1'b1;
				if (cmd_in_range) begin
					nxt.masks = cur.masks | cmd_sel;
					if ((cur.levels & cmd_sel) == '0) begin
						nxt.levels = cur.levels | cmd_sel;
						change.valid = 1'b1;
					end
				end
			end
			MODE_FORCE_OFF: begin
				if (cmd_in_range) begin
					nxt.masks = cur.masks | cmd_sel;
					if ((cur.levels & cmd_sel) != '0) begin
						nxt.levels = cur.levels & ~cmd_sel;
						change.valid = 1'b1;
					end
				end
			end
			MODE_RELEASE: begin
				if (cmd_in_range) begin
					nxt.masks = cur.masks & ~cmd_sel;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

/* sv/gpi_status_frame_parser_core.sv */
// Top level of the GPI status frame parser: input stage, parser state and result register.
// The block takes one word per clock cycle unless out_ready holds back a change word, and
// answers a word with at most one change word: the input stage registers the word, then
// one pass of next-state logic updates the frame position, pin levels and pin masks and
// loads the result register. The input side keeps taking words while a change word waits,
// until the input stage is full; in_ready then drops only while out_ready is low.
// Configuration writes are always taken and should arrive only while the block is idle.
module gpi_status_frame_parser_core
	import gspf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [MODE_W-1:0] mode,
	input logic [BYTE_W-1:0] status_byte,
	input logic [PIN_W-1:0] pin_select,
	output logic out_valid,
	input logic out_ready,
	output logic [PIN_W-1:0] changed_pin,
	output logic new_level,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [UNIT_W-1:0] unit_number
);

	logic valid_s1;
	logic [MODE_W-1:0] mode_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [PIN_W-1:0] pin_s1;
	logic [UNIT_W-1:0] unit_q;
	parse_state_t state_q;
	parse_state_t state_nxt;
	change_t change;
	logic out_valid_q;
	logic [PIN_W-1:0] changed_pin_q;
	logic new_level_q;
	logic fire;

	assign fire = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign changed_pin = changed_pin_q;
	assign new_level = new_level_q;

	gspf_step u_step (
		.cur(state_q),
		.unit_number(unit_q),
		.mode(mode_s1),
		.status_byte(byte_s1),
		.pin_select(pin_s1),
		.nxt(state_nxt),
		.change(change)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			unit_q <= '0;
			state_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unit_q <= unit_number;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (fire) begin
				state_q <= state_nxt;
				out_valid_q <= change.valid;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= mode;
			byte_s1 <= status_byte;
			pin_s1 <= pin_select;
		end
		if (fire && change.valid) begin
			changed_pin_q <= change.pin;
			new_level_q <= change.level;
		end
	end

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pos <= POS_W'(LAST_DIGIT_POS + 1))
		else $error("Frame position beyond the last digit.");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out_ready |-> !in_ready)
		else $error("Input taken while the input stage is blocked.");

	a_release_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		fire && mode_s1 == MODE_RELEASE |=> !out_valid_q)
		else $error("Release produced a change word.");

	a_level_match: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> state_q.levels[changed_pin_q] == new_level_q)
		else $error("Change word disagrees with the stored pin level.");
`endif

endmodule

/* tb/tb_gpi_status_frame_parser_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the GPI status frame parser core, with its change predictor.

class pin_change_predictor;
	typedef struct packed {
		logic [gspf_pkg::PIN_W-1:0] pin;
		logic level;
	} pin_change_t;

	typedef enum logic [gspf_pkg::POS_W-1:0] {
		POS_IDLE = 0,
		POS_GOT_S = 1,
		POS_GOT_UNIT = 2,
		POS_GOT_P = 3,
		POS_GOT_COMMA = 4,
		POS_GOT_A = 5
	} header_pos_t;

	logic [gspf_pkg::UNIT_W-1:0] unit;
	gspf_pkg::pos_t pos;
	gspf_pkg::pins_t levels;
	gspf_pkg::pins_t masks;
	pin_change_t pending_changes[$];
	int mismatches;

	function new();
		unit = '0;
		pos = POS_IDLE;
		levels = '0;
		masks = '0;
		mismatches = 0;
	endfunction

	function void set_unit(input logic [gspf_pkg::UNIT_W-1:0] value);
		unit = value;
	endfunction

	function int pending();
		return pending_changes.size();
	endfunction

	function void note_word(input logic [gspf_pkg::MODE_W-1:0] mode,
			input logic [gspf_pkg::BYTE_W-1:0] b, input logic [gspf_pkg::PIN_W-1:0] psel);
		int k;
		logic lvl;
		if (mode == gspf_pkg::MODE_STATUS) begin
			if (pos == POS_IDLE) begin
				if (b == gspf_pkg::CH_S)
					pos = POS_GOT_S;
			end else if (pos == POS_GOT_S) begin
				pos = (b == gspf_pkg::BYTE_W'(gspf_pkg::CH_ZERO + unit)) ? POS_GOT_UNIT : POS_IDLE;
			end else if (pos == POS_GOT_UNIT) begin
				pos = (b == gspf_pkg::CH_P) ? POS_GOT_P : POS_IDLE;
			end else if (pos == POS_GOT_P) begin
				pos = (b == gspf_pkg::CH_COMMA) ? POS_GOT_COMMA : POS_IDLE;
			end else if (pos == POS_GOT_COMMA) begin
				pos = (b == gspf_pkg::CH_A) ? POS_GOT_A : POS_IDLE;
			end else if (pos > gspf_pkg::LAST_DIGIT_POS) begin
				pos = POS_IDLE;
			end else if (pos[0]) begin
				pos = (b == gspf_pkg::CH_COMMA) ? pos + 1'b1 : POS_IDLE;
			end else if (b == gspf_pkg::CH_ZERO || b == gspf_pkg::CH_ONE) begin
				k = (int'(pos) - gspf_pkg::FIRST_DIGIT_POS) >> 1;
				lvl = (b == gspf_pkg::CH_ONE);
				pos = pos + 1'b1;
				if (!masks[k] && levels[k] != lvl) begin
					levels[k] = lvl;
					pending_changes.push_back('{pin: k[gspf_pkg::PIN_W-1:0], level: lvl});
				end
			end
		end else if (int'(psel) < gspf_pkg::PIN_COUNT) begin
			if (mode == gspf_pkg::MODE_RELEASE) begin
				masks[psel] = 1'b0;
			end else begin
				masks[psel] = 1'b1;
				lvl = (mode == gspf_pkg::MODE_FORCE_ON);
				if (levels[psel] != lvl) begin
					levels[psel] = lvl;
					pending_changes.push_back('{pin: psel, level: lvl});
				end
			end
		end
	endfunction

	function void check_change(input logic [gspf_pkg::PIN_W-1:0] pin, input logic level);
		pin_change_t want;
		if (pending_changes.size() == 0) begin
			$error("unexpected change word: changed_pin=%0d new_level=%0d", pin, level);
			mismatches++;
		end else begin
			want = pending_changes.pop_front();
			if (pin !== want.pin) begin
				$error("changed_pin: expected %0d, actual %0d", want.pin, pin);
				mismatches++;
			end
			if (level !== want.level) begin
				$error("new_level: expected %0d, actual %0d", want.level, level);
				mismatches++;
			end
		end
	endfunction
endclass

module tb_gpi_status_frame_parser_core;
	import gspf_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_AFTER_WORDS = 400;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_WORDS = 300;
	localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [MODE_W-1:0] mode;
	logic [BYTE_W-1:0] status_byte;
	logic [PIN_W-1:0] pin_select;
	logic out_valid;
	logic out_ready;
	logic [PIN_W-1:0] changed_pin;
	logic new_level;
	logic cfg_valid;
	logic cfg_ready;
	logic [UNIT_W-1:0] unit_number;

	pin_change_predictor tracker = new();
	int words_in = 0;
	int cycles = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int stall_left = 0;
	bit long_hold_done = 1'b0;

	gpi_status_frame_parser_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.status_byte(status_byte),
		.pin_select(pin_select),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.changed_pin(changed_pin),
		.new_level(new_level),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.unit_number(unit_number)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_gpi_status_frame_parser_core: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_change(changed_pin, new_level);
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!long_hold_done && words_in >= HOLD_AFTER_WORDS) begin
				long_hold_done = 1'b1;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
				stall_left = $urandom_range(1, 19);
			end
			if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	task automatic send_word(input logic [MODE_W-1:0] m, input logic [BYTE_W-1:0] b,
			input logic [PIN_W-1:0] p);
		int gap;
		if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			gap = $urandom_range(1, 19);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		mode = m;
		status_byte = b;
		pin_select = p;
		do @(posedge clk); while (!in_ready);
		tracker.note_word(m, b, p);
		words_in++;
		@(negedge clk);
	endtask

	task automatic send_status(input logic [BYTE_W-1:0] b);
		send_word(MODE_STATUS, b, PIN_W'($urandom_range(0, 15)));
	endtask

	task automatic send_command();
		send_word(MODE_W'($urandom_range(1, 3)), BYTE_W'($urandom_range(0, 255)),
			PIN_W'($urandom_range(0, 15)));
	endtask

	task automatic write_unit(input logic [UNIT_W-1:0] value);
		in_valid = 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (5) @(negedge clk);
		cfg_valid = 1'b1;
		unit_number = value;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_unit(value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_frame(input bit broken);
		logic [BYTE_W-1:0] fb[$];
		logic [BYTE_W-1:0] junk;
		int idx;
		fb.delete();
		fb.push_back(CH_S);
		fb.push_back(BYTE_W'(CH_ZERO + tracker.unit));
		fb.push_back(CH_P);
		fb.push_back(CH_COMMA);
		fb.push_back(CH_A);
		for (int k = 0; k < PIN_COUNT; k++) begin
			fb.push_back(CH_COMMA);
			fb.push_back($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
		end
		if (broken) begin
			idx = $urandom_range(0, fb.size() - 1);
			fb[idx] = BYTE_W'($urandom_range(0, 255));
		end
		foreach (fb[i]) begin
			if ($urandom_range(0, 15) == 0)
				send_command();
			if (i >= FIRST_DIGIT_POS && (i % 2) == 0 && $urandom_range(0, 11) == 0) begin
				junk = BYTE_W'($urandom_range(0, 255));
				if (junk == CH_ZERO || junk == CH_ONE)
					junk = junk ^ 8'h80;
				send_status(junk);
			end
			send_status(fb[i]);
		end
		send_status($urandom_range(0, 1) ? CH_S : BYTE_W'($urandom_range(0, 255)));
		send_status(CH_CR);
	endtask

	task automatic run_phase(input int words);
		int target;
		int sel;
		target = words_in + words;
		while (words_in < target) begin
			sel = $urandom_range(0, 19);
			if (sel < 12)
				send_frame(1'b0);
			else if (sel < 15)
				send_frame(1'b1);
			else if (sel < 18)
				repeat ($urandom_range(1, 4)) send_command();
			else
				repeat ($urandom_range(1, 6)) send_status(BYTE_W'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_STATUS;
		status_byte = '0;
		pin_select = '0;
		cfg_valid = 1'b0;
		unit_number = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Short directed sequence with the unit number still at its reset value.
		send_status(8'h00);
		send_status(8'hFF);
		send_status(CH_S);
		send_status(CH_ONE);
		send_status(CH_S);
		send_status(CH_ZERO);
		send_status(CH_P);
		send_status(CH_COMMA);
		send_status(CH_A);
		send_status(CH_COMMA);
		send_status(CH_ONE);
		send_status(CH_COMMA);
		send_status(CH_ONE + 8'd1);
		send_word(MODE_FORCE_ON, 8'hA5, 4'd1);
		send_status(CH_ZERO);
		send_status(CH_P);
		send_word(MODE_FORCE_OFF, 8'h5A, 4'd15);
		send_word(MODE_FORCE_ON, 8'h00, 4'd15);
		send_word(MODE_FORCE_OFF, 8'hFF, 4'd15);
		send_word(MODE_RELEASE, 8'h00, 4'd15);
		send_word(MODE_RELEASE, 8'hFF, 4'd1);
		send_word(MODE_FORCE_OFF, 8'h00, 4'd0);
		send_word(MODE_RELEASE, 8'hFF, 4'd0);
		send_status(CH_S);
		send_status(CH_ZERO);
		send_status(CH_A);

		write_unit(4'd9);
		tx_idle_pct = 10;
		rx_idle_pct = 4;
		run_phase(PHASE_WORDS);

		write_unit(4'd0);
		tx_idle_pct = 0;
		rx_idle_pct = 8;
		run_phase(PHASE_WORDS);

		write_unit(4'd15);
		tx_idle_pct = 25;
		rx_idle_pct = 0;
		run_phase(PHASE_WORDS);

		write_unit(UNIT_W'($urandom_range(0, 15)));
		tx_idle_pct = 5;
		rx_idle_pct = 2;
		run_phase(PHASE_WORDS);

		write_unit(UNIT_W'($urandom_range(0, 9)));
		tx_idle_pct = 15;
		rx_idle_pct = 6;
		run_phase(PHASE_WORDS);

		write_unit(UNIT_W'($urandom_range(0, 15)));
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_phase(PHASE_WORDS);

		in_valid = 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("tb_gpi_status_frame_parser_core: PASS");
		end else begin
			$display("tb_gpi_status_frame_parser_core: FAIL");
		end
		$finish;
	end

endmodule
